[rtl/lcw_pkg.sv]
// Shared types and constants for the LCW frame decompressor.
package lcw_pkg;

  localparam int HISTORY_DEPTH = 65536;
  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int SW = (CW > 16) ? CW : 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QW = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_PULL  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam logic [7:0] END_CODE    = 8'h80;
  localparam logic [7:0] FILL_CODE   = 8'hfe;
  localparam logic [7:0] LONG_CODE   = 8'hff;
  localparam logic [7:0] TYPE_MASK   = 8'hc0;
  localparam logic [7:0] LIT_TYPE    = 8'h80;
  localparam logic [15:0] COPY_BIAS  = 16'd3;

  typedef enum logic [2:0] {
    PH_FIRST = 3'd0,
    PH_CMD   = 3'd1,
    PH_OP1   = 3'd2,
    PH_OP2   = 3'd3,
    PH_OP3   = 3'd4,
    PH_OP4   = 3'd5,
    PH_RUN   = 3'd6,
    PH_DONE  = 3'd7
  } phase_t;

  typedef struct packed {
    logic          need_read;
    logic          write;
    logic [AW-1:0] src;
    logic [AW-1:0] dst;
    logic [7:0]    value;
    logic          frame_end;
    logic          error;
  } op_t;

endpackage

[rtl/lcw_front.sv]
// Command parser: tracks frame state and issues history operations.
module lcw_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [15:0]       cfg_data,
  input  logic              accept,
  input  logic [1:0]        cmd,
  input  logic [7:0]        data_byte,
  output logic              push,
  output lcw_pkg::op_t      op
);

  lcw_pkg::phase_t              phase, phase_next, eff;
  logic                         rel, rel_next;
  logic [15:0]                  pend, pend_next, pend_dec;
  logic [lcw_pkg::CW-1:0]       src, src_next;
  logic [7:0]                   fill, fill_next;
  logic [15:0]                  bc, bc_next, bc_sat;
  logic [7:0]                   held, held_next;
  logic [lcw_pkg::CW-1:0]       wc, wc_next;
  logic [15:0]                  compressed_size;
  logic                         go;
  logic                         held_lit;
  logic                         hist_full;
  logic [15:0]                  word;

  function automatic logic [lcw_pkg::CW-1:0] back_source(
    input logic [lcw_pkg::CW-1:0] count, input logic [15:0] d);
    logic [lcw_pkg::SW-1:0] de, ce;
    de = lcw_pkg::SW'(d);
    ce = lcw_pkg::SW'(count);
    if (de <= ce) begin
      return lcw_pkg::CW'(ce - de);
    end
    return lcw_pkg::CW'(lcw_pkg::HISTORY_DEPTH);
  endfunction

  function automatic logic [lcw_pkg::CW-1:0] abs_source(input logic [15:0] p);
    if (lcw_pkg::SW'(p) >= lcw_pkg::SW'(lcw_pkg::HISTORY_DEPTH)) begin
      return lcw_pkg::CW'(lcw_pkg::HISTORY_DEPTH);
    end
    return lcw_pkg::CW'(p);
  endfunction

  assign pend_dec  = pend - 16'd1;
  assign bc_sat    = (bc != 16'hffff) ? bc + 16'd1 : bc;
  assign held_lit  = (held & lcw_pkg::TYPE_MASK) == lcw_pkg::LIT_TYPE;
  assign hist_full = wc == lcw_pkg::CW'(lcw_pkg::HISTORY_DEPTH);
  assign word      = {data_byte, src[7:0]};

  always_comb begin
    phase_next = phase;
    rel_next   = rel;
    pend_next  = pend;
    src_next   = src;
    fill_next  = fill;
    bc_next    = bc;
    held_next  = held;
    wc_next    = wc;
    push       = 1'b0;
    op         = '0;
    eff        = phase;
    go         = 1'b0;
    if (accept) begin
      unique case (cmd)
        lcw_pkg::CMD_BYTE: begin
          if (phase == lcw_pkg::PH_FIRST && data_byte == 8'h00) begin
            rel_next   = 1'b1;
            phase_next = lcw_pkg::PH_CMD;
          end else begin
            if (phase == lcw_pkg::PH_FIRST) begin
              eff        = lcw_pkg::PH_CMD;
              phase_next = lcw_pkg::PH_CMD;
            end
            go = (eff != lcw_pkg::PH_DONE) && !(eff == lcw_pkg::PH_RUN && !held_lit);
          end
          if (go) begin
            bc_next = bc_sat;
            unique case (eff)
              lcw_pkg::PH_CMD: begin
                if (data_byte == lcw_pkg::END_CODE || bc_sat >= compressed_size) begin
                  push         = 1'b1;
                  op.frame_end = 1'b1;
                  phase_next   = lcw_pkg::PH_DONE;
                end else begin
                  held_next = data_byte;
                  if ((data_byte & lcw_pkg::TYPE_MASK) == lcw_pkg::LIT_TYPE) begin
                    pend_next  = {10'd0, data_byte[5:0]};
                    phase_next = (data_byte[5:0] != 6'd0) ? lcw_pkg::PH_RUN : lcw_pkg::PH_CMD;
                  end else begin
                    phase_next = lcw_pkg::PH_OP1;
                  end
                end
              end
              lcw_pkg::PH_OP1: begin
                if (!held[7]) begin
                  pend_next  = 16'(held[6:4]) + lcw_pkg::COPY_BIAS;
                  src_next   = back_source(wc, {4'd0, held[3:0], data_byte});
                  phase_next = lcw_pkg::PH_RUN;
                end else if (held == lcw_pkg::FILL_CODE || held == lcw_pkg::LONG_CODE) begin
                  pend_next  = 16'(data_byte);
                  phase_next = lcw_pkg::PH_OP2;
                end else begin
                  src_next   = lcw_pkg::CW'(data_byte);
                  phase_next = lcw_pkg::PH_OP2;
                end
              end
              lcw_pkg::PH_OP2: begin
                if (held == lcw_pkg::FILL_CODE || held == lcw_pkg::LONG_CODE) begin
                  pend_next  = {data_byte, pend[7:0]};
                  phase_next = lcw_pkg::PH_OP3;
                end else begin
                  pend_next  = 16'(held[5:0]) + lcw_pkg::COPY_BIAS;
                  src_next   = rel ? back_source(wc, word) : abs_source(word);
                  phase_next = lcw_pkg::PH_RUN;
                end
              end
              lcw_pkg::PH_OP3: begin
                if (held == lcw_pkg::FILL_CODE) begin
                  fill_next  = data_byte;
                  phase_next = (pend != 16'd0) ? lcw_pkg::PH_RUN : lcw_pkg::PH_CMD;
                end else begin
                  src_next   = lcw_pkg::CW'(data_byte);
                  phase_next = lcw_pkg::PH_OP4;
                end
              end
              lcw_pkg::PH_OP4: begin
                src_next   = rel ? back_source(wc, word) : abs_source(word);
                phase_next = (pend != 16'd0) ? lcw_pkg::PH_RUN : lcw_pkg::PH_CMD;
              end
              lcw_pkg::PH_RUN: begin
                push = 1'b1;
                if (hist_full) begin
                  op.error   = 1'b1;
                  phase_next = lcw_pkg::PH_DONE;
                end else begin
                  op.write  = 1'b1;
                  op.dst    = wc[lcw_pkg::AW-1:0];
                  op.value  = data_byte;
                  wc_next   = wc + 1'b1;
                  pend_next = pend_dec;
                  if (pend_dec == 16'd0) begin
                    phase_next = lcw_pkg::PH_CMD;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        lcw_pkg::CMD_PULL: begin
          if (phase == lcw_pkg::PH_RUN && !held_lit) begin
            push = 1'b1;
            if (hist_full || (held != lcw_pkg::FILL_CODE && src >= wc)) begin
              op.error   = 1'b1;
              phase_next = lcw_pkg::PH_DONE;
            end else begin
              op.write = 1'b1;
              op.dst   = wc[lcw_pkg::AW-1:0];
              if (held == lcw_pkg::FILL_CODE) begin
                op.value = fill;
              end else begin
                op.need_read = 1'b1;
                op.src       = src[lcw_pkg::AW-1:0];
                src_next     = src + 1'b1;
              end
              wc_next   = wc + 1'b1;
              pend_next = pend_dec;
              if (pend_dec == 16'd0) begin
                phase_next = lcw_pkg::PH_CMD;
              end
            end
          end
        end
        lcw_pkg::CMD_START: begin
          phase_next = lcw_pkg::PH_FIRST;
          rel_next   = 1'b0;
          pend_next  = '0;
          src_next   = '0;
          fill_next  = '0;
          bc_next    = '0;
          held_next  = '0;
          wc_next    = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= lcw_pkg::PH_FIRST;
      rel             <= 1'b0;
      pend            <= '0;
      src             <= '0;
      fill            <= '0;
      bc              <= '0;
      held            <= '0;
      wc              <= '0;
      compressed_size <= '0;
    end else begin
      phase <= phase_next;
      rel   <= rel_next;
      pend  <= pend_next;
      src   <= src_next;
      fill  <= fill_next;
      bc    <= bc_next;
      held  <= held_next;
      wc    <= wc_next;
      if (cfg_write) begin
        compressed_size <= cfg_data;
      end
    end
  end

endmodule

[rtl/lcw_queue.sv]
// Short operation queue between the parser and the history engine.
module lcw_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  lcw_pkg::op_t push_op,
  input  logic         pop,
  output lcw_pkg::op_t head,
  output logic         empty,
  output logic         full
);

  lcw_pkg::op_t          slots [lcw_pkg::QUEUE_DEPTH];
  logic [lcw_pkg::QW-1:0] wr_ptr, rd_ptr;
  logic [lcw_pkg::QW:0]   count;

  assign head  = slots[rd_ptr];
  assign empty = count == '0;
  assign full  = count == (lcw_pkg::QW + 1)'(lcw_pkg::QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/lcw_back.sv]
// History engine: history RAM access, write-to-read forwarding, result register.
module lcw_back (
  input  logic         clk,
  input  logic         rst,
  input  lcw_pkg::op_t head,
  input  logic         empty,
  output logic         pop,
  output logic         result_valid,
  input  logic         result_stall,
  output logic [7:0]   out_byte,
  output logic         frame_end,
  output logic         error
);

  logic [7:0]   mem [lcw_pkg::HISTORY_DEPTH];
  logic [7:0]   ram_q;
  lcw_pkg::op_t r1;
  logic         r1_valid;
  logic         r1_move;
  logic [7:0]   r1_data;
  logic         fwd;
  logic [7:0]   fwd_val;

  assign r1_move = r1_valid && (!result_valid || !result_stall);
  assign pop     = !empty && (!r1_valid || r1_move);
  assign r1_data = r1.need_read ? (fwd ? fwd_val : ram_q) : r1.value;

  always_ff @(posedge clk) begin
    if (r1_move && r1.write) begin
      mem[r1.dst] <= r1_data;
    end
    if (pop) begin
      ram_q <= mem[head.src];
    end
  end

  // a write retiring on the same edge as the read is not seen by the RAM
  always_ff @(posedge clk) begin
    if (pop) begin
      r1      <= head;
      fwd     <= r1_move && r1.write && (r1.dst == head.src);
      fwd_val <= r1_data;
    end
    if (r1_move) begin
      out_byte  <= r1_data;
      frame_end <= r1.frame_end;
      error     <= r1.error;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        r1_valid <= 1'b1;
      end else if (r1_move) begin
        r1_valid <= 1'b0;
      end
      if (r1_move) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/lcw_decompressor_top.sv]
// LCW frame decompressor top level.
// Input channel (item_valid/item_stall): cmd 0 carries one compressed byte in
// data_byte, cmd 1 pulls one byte of a pending copy or fill, cmd 2 starts a
// new frame. Result channel (result_valid/result_stall): out_byte with the
// frame_end and error flags; literal bytes and pulls give one result each,
// the closing command or a failed write gives one flagged result with byte 0.
// The user loads compressed_size via cfg_write/cfg_data only while the block is
// idle; the block does not enforce this. Items pass the queue, r1 and the
// result register. Throughput: one item per cycle while item_stall is low; the
// parser, a 4-entry queue and the history RAM pipeline (one read and one write
// port, read data registered) each take one op per cycle, with the last write
// forwarded to a following read. Reset clears the parser state, queue, and the
// r1 and result valid flags; compressed_size returns to 0. History contents are
// not cleared. When the receiver stalls, the result holds, the RAM pipeline
// fills, then the queue fills and item_stall rises until space frees up.
module lcw_decompressor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  out_byte,
  output logic        frame_end,
  output logic        error
);

  lcw_pkg::op_t push_op, head;
  logic         push, pop, empty, full, accept;

  assign item_stall = full;
  assign accept     = item_valid && !item_stall;

  lcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .cmd       (cmd),
    .data_byte (data_byte),
    .push      (push),
    .op        (push_op)
  );

  lcw_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .empty   (empty),
    .full    (full)
  );

  lcw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .frame_end    (frame_end),
    .error        (error)
  );

endmodule

[rtl/lcw_checker.sv]
// Port-level assertions for the LCW decompressor, bound to the top level.
module lcw_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_stall,
  input logic [7:0] out_byte,
  input logic       frame_end,
  input logic       error
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_hold_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(out_byte))
    else $error("stalled result changed");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (frame_end || error) |-> out_byte == 8'h00)
    else $error("end or error result carries data");

  a_flag_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(frame_end && error))
    else $error("end and error on one result");

endmodule

bind lcw_decompressor_top lcw_checker u_lcw_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .out_byte     (out_byte),
  .frame_end    (frame_end),
  .error        (error)
);
